/* design/utf8_vowel_stretcher_assert.svh */
// Assertion macros for the UTF-8 vowel stretcher checker.
// Needs nothing else; included by files that assert.
`ifndef UTF8_VOWEL_STRETCHER_ASSERT_SVH
`define UTF8_VOWEL_STRETCHER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UVS_ASSERT_IMP(lbl, c, r, a, q) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (q)) \
    else $error("uvs: same-cycle check failed");

// next-cycle implication, disabled during reset
`define UVS_ASSERT_NXT(lbl, c, r, a, q) \
  lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (q)) \
    else $error("uvs: next-cycle check failed");

`endif

/* design/uvs_pkg.sv */
// Shared types, constants and the vowel whitelist for the vowel stretcher.
// No dependencies.
`default_nettype none

package uvs_pkg;

  localparam int CFG_W = 10;

  typedef logic [7:0] byte_t;

  // one decoded character plus the number of extra copies to emit
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      len_m1;
    logic [1:0]      copies;
  } job_t;

  typedef struct packed {
    logic load;
    job_t job;
  } job_req_t;

  function automatic logic is_vowel(input logic [10:0] cp);
    logic hit;
    case (cp) inside
      11'h061, 11'h041, 11'h065, 11'h045, 11'h069, 11'h049,
      11'h06F, 11'h04F, 11'h075, 11'h055, 11'h079, 11'h059,
      11'h0E6, 11'h0C6, 11'h0F8, 11'h0D8, 11'h153, 11'h152,
      11'h250, 11'h251, 11'h252, 11'h254, 11'h259, 11'h25A,
      11'h25B, 11'h25C, 11'h25D, 11'h25E, 11'h264, 11'h268,
      11'h26A, 11'h26F, 11'h275, 11'h276, 11'h289, 11'h28A,
      11'h28C, 11'h28F: hit = 1'b1;
      default:          hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

/* design/uvs_if.sv */
// Valid/ready channel interfaces for the vowel stretcher input and result.
// No dependencies.
`default_nettype none

interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic [2:0] bytes_left;
  logic       first_of_string;

  modport source(output valid, output in_byte, output bytes_left,
                 output first_of_string, input ready);
  modport sink(input valid, input in_byte, input bytes_left,
               input first_of_string, output ready);
endinterface

interface uvs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       is_duplicate;

  modport source(output valid, output out_byte, output run_last,
                 output is_duplicate, input ready);
  modport sink(input valid, input out_byte, input run_last,
               input is_duplicate, output ready);
endinterface

`default_nettype wire

/* design/uvs_decode.sv */
// Character assembly, vowel test and stretch accumulator.
// Depends on uvs_pkg.
`default_nettype none

module uvs_decode #(
  parameter int ACC_FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [uvs_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        accept,
  input  logic [7:0]                  in_byte,
  input  logic [2:0]                  bytes_left,
  input  logic                        first_of_string,
  output uvs_pkg::job_req_t           req
);
  import uvs_pkg::*;

  localparam int AW = ACC_FRACTION_BITS + 2;
  localparam int CW = (AW > CFG_W) ? AW : CFG_W;
  localparam logic [CW-1:0] EXTRA_MAX = {{(CW-1){1'b0}}, 1'b1} << (ACC_FRACTION_BITS + 1);
  localparam logic [AW-1:0] ACC_ONE   = {{(AW-1){1'b0}}, 1'b1} << ACC_FRACTION_BITS;
  localparam logic [AW-1:0] ACC_TWO   = ACC_ONE << 1;

  logic [CFG_W-1:0] extra_r;
  logic [AW-1:0]    acc_r, acc_nxt;
  byte_t            pend_r [3];
  logic [1:0]       pend_cnt_r, pend_cnt_nxt;
  logic [2:0]       exp_len_r, exp_len_nxt;

  logic [1:0]  cnt_eff;
  logic [2:0]  exp_eff;
  logic [AW-1:0] acc_eff;
  logic [2:0]  left;
  logic [2:0]  lead_len;
  logic        store;
  logic [1:0]  store_idx;
  logic        emit;
  logic        vowel_ok;
  logic [2:0]  clen;
  byte_t       ch [4];
  logic [10:0] cp;
  logic        vowel;
  logic [CW-1:0] extra_w;
  logic [AW-1:0] extra_c;
  logic [AW-1:0] sum;
  logic [1:0]  copies;

  // a first byte starts from a clean state
  assign cnt_eff = first_of_string ? 2'd0 : pend_cnt_r;
  assign exp_eff = first_of_string ? 3'd0 : exp_len_r;
  assign acc_eff = first_of_string ? '0 : acc_r;
  assign left    = (bytes_left > 3'd4) ? 3'd4 : bytes_left;

  always_comb begin
    lead_len = 3'd0;
    if (left != 3'd0) begin
      if (!in_byte[7])                                  lead_len = 3'd1;
      else if (in_byte[7:5] == 3'b110 && left >= 3'd2)  lead_len = 3'd2;
      else if (in_byte[7:4] == 4'b1110 && left >= 3'd3) lead_len = 3'd3;
      else if (in_byte[7:3] == 5'b11110 && left >= 3'd4) lead_len = 3'd4;
    end
  end

  // assembled character: pending bytes then the current byte
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ch[k] = (2'(k) < cnt_eff) ? pend_r[k] : in_byte;
    end
    ch[3] = in_byte;
    if (exp_eff == 3'd0) ch[0] = in_byte;
  end

  always_comb begin
    store        = 1'b0;
    store_idx    = 2'd0;
    emit         = 1'b0;
    vowel_ok     = 1'b0;
    clen         = 3'd1;
    pend_cnt_nxt = cnt_eff;
    exp_len_nxt  = exp_eff;
    if (exp_eff == 3'd0) begin
      if (lead_len == 3'd0) begin
        emit = 1'b1;                 // raw passthrough
      end else if (lead_len == 3'd1) begin
        emit     = 1'b1;
        vowel_ok = 1'b1;
      end else begin
        store        = 1'b1;
        pend_cnt_nxt = 2'd1;
        exp_len_nxt  = lead_len;
      end
    end else if (({1'b0, cnt_eff} + 3'd1 < exp_eff) && cnt_eff != 2'd3) begin
      store        = 1'b1;
      store_idx    = cnt_eff;
      pend_cnt_nxt = cnt_eff + 2'd1;
    end else begin
      emit         = 1'b1;
      vowel_ok     = 1'b1;
      clen         = {1'b0, cnt_eff} + 3'd1;
      pend_cnt_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end
  end

  // 3 and 4 byte forms never count as vowels
  assign cp    = (clen == 3'd1) ? {3'b000, ch[0]} : {ch[0][4:0], ch[1][5:0]};
  assign vowel = vowel_ok && (clen == 3'd1 || clen == 3'd2) && is_vowel(cp)
                 && (extra_r != '0);

  assign extra_w = CW'(extra_r);
  assign extra_c = (extra_w > EXTRA_MAX) ? AW'(EXTRA_MAX) : AW'(extra_w);
  assign sum     = acc_eff + extra_c;

  always_comb begin
    copies  = 2'd0;
    acc_nxt = acc_eff;
    if (vowel) begin
      if (sum >= ACC_TWO) begin
        copies  = 2'd2;
        acc_nxt = sum - ACC_TWO;
      end else if (sum >= ACC_ONE) begin
        copies  = 2'd1;
        acc_nxt = sum - ACC_ONE;
      end else begin
        acc_nxt = sum;
      end
    end
  end

  always_comb begin
    req.load       = emit;
    req.job.bytes  = {ch[3], ch[2], ch[1], ch[0]};
    req.job.len_m1 = 2'(clen - 3'd1);
    req.job.copies = copies;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_r    <= '0;
      acc_r      <= '0;
      pend_cnt_r <= 2'd0;
      exp_len_r  <= 3'd0;
    end else begin
      if (cfg_we) extra_r <= cfg_wdata;
      if (accept) begin
        acc_r      <= acc_nxt;
        pend_cnt_r <= pend_cnt_nxt;
        exp_len_r  <= exp_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) pend_r[store_idx] <= in_byte;
  end

endmodule

`default_nettype wire

/* design/utf8_vowel_stretcher.sv */
// UTF-8 vowel stretcher. Each accepted byte is decoded in the cycle it
// transfers; a completed character (with any vowel copies) is loaded into
// the emitter register. Unless the output stalls, it sends one result byte
// per cycle and single-byte characters stream at one per cycle, as the next
// byte is taken in the cycle the last result byte transfers. A byte that
// causes n results (1 to 6; 1 to 4 for a non-vowel character of up to four
// bytes, up to 6 for a two byte vowel with two copies) holds the emitter
// until all n transfer; a byte that only extends a partial character loads none.
// Depends on uvs_pkg, uvs_if and uvs_decode.
`default_nettype none

module utf8_vowel_stretcher #(
  parameter int ACC_FRACTION_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  uvs_in_if.sink                    in_chan,
  uvs_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [uvs_pkg::CFG_W-1:0] cfg_wdata
);
  import uvs_pkg::*;

  job_req_t   req;
  job_t       job_r;
  logic       busy_r;
  logic [1:0] pos_r;
  logic [1:0] copy_r;
  logic       last_byte;
  logic       in_xfer;
  logic       out_xfer;
  logic       load;

  assign last_byte       = (pos_r == job_r.len_m1) && (copy_r == job_r.copies);
  assign out_xfer        = busy_r && out_chan.ready;
  assign in_chan.ready   = !busy_r || (out_chan.ready && last_byte);
  assign in_xfer         = in_chan.valid && in_chan.ready;
  assign load            = in_xfer && req.load;

  uvs_decode #(
    .ACC_FRACTION_BITS(ACC_FRACTION_BITS)
  ) u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .accept          (in_xfer),
    .in_byte         (in_chan.in_byte),
    .bytes_left      (in_chan.bytes_left),
    .first_of_string (in_chan.first_of_string),
    .req             (req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 2'd0;
      copy_r <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= 2'd0;
      copy_r <= 2'd0;
    end else if (out_xfer) begin
      if (last_byte) begin
        busy_r <= 1'b0;
      end else if (pos_r == job_r.len_m1) begin
        pos_r  <= 2'd0;
        copy_r <= copy_r + 2'd1;
      end else begin
        pos_r  <= pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= req.job;
  end

  assign out_chan.valid        = busy_r;
  assign out_chan.out_byte     = job_r.bytes[pos_r];
  assign out_chan.run_last     = last_byte;
  assign out_chan.is_duplicate = (copy_r != 2'd0);

endmodule

`default_nettype wire

/* design/uvs_check.sv */
// Port-level checker for the vowel stretcher, bound to the top level.
// Depends on utf8_vowel_stretcher_assert.svh and utf8_vowel_stretcher.
`default_nettype none
`include "utf8_vowel_stretcher_assert.svh"

module uvs_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       is_duplicate
);

  // stalled result holds its byte
  `UVS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))

  // a character in flight keeps emitting until its last byte
  `UVS_ASSERT_NXT(a_run_cont, clk, rst_n, out_valid && out_ready && !run_last, out_valid)

  // copies stay marked as copies to the end of the run
  `UVS_ASSERT_NXT(a_dup_cont, clk, rst_n, out_valid && out_ready && !run_last && is_duplicate, is_duplicate)

  // no new byte taken while a run is unfinished
  `UVS_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid && !run_last, !in_ready)

  // run done and nothing taken: output goes idle
  `UVS_ASSERT_NXT(a_drain, clk, rst_n, out_valid && out_ready && run_last && !(in_valid && in_ready), !out_valid)

endmodule

bind utf8_vowel_stretcher uvs_check u_uvs_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_byte     (out_chan.out_byte),
  .run_last     (out_chan.run_last),
  .is_duplicate (out_chan.is_duplicate)
);

`default_nettype wire

/* tb/sv/utf8_vowel_stretcher_tb.sv */
// Self-checking bench for utf8_vowel_stretcher: predicts the stretched byte stream
// for every accepted input byte and compares it with each result transfer.
// Depends on uvs_pkg, uvs_if and the stretcher RTL.
`timescale 1ns / 100ps

module utf8_vowel_stretcher_tb;

  localparam int FRAC_BITS = 8;
  localparam int ACC_W     = FRAC_BITS + 2;
  localparam int ACC_ONE   = 1 << FRAC_BITS;
  localparam int EXTRA_MAX = 2 << FRAC_BITS;

  // stretchable code points: ASCII first, then the two-byte ones
  localparam logic [10:0] VOWELS [38] = '{
    11'h061, 11'h041, 11'h065, 11'h045, 11'h069, 11'h049,
    11'h06F, 11'h04F, 11'h075, 11'h055, 11'h079, 11'h059,
    11'h0E6, 11'h0C6, 11'h0F8, 11'h0D8, 11'h153, 11'h152,
    11'h250, 11'h251, 11'h252, 11'h254, 11'h259, 11'h25A,
    11'h25B, 11'h25C, 11'h25D, 11'h25E, 11'h264, 11'h268,
    11'h26A, 11'h26F, 11'h275, 11'h276, 11'h289, 11'h28A,
    11'h28C, 11'h28F
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       dup;
  } out_beat_t;

  function automatic bit stretchable(input logic [10:0] cp);
    foreach (VOWELS[i]) begin
      if (VOWELS[i] == cp) return 1'b1;
    end
    return 1'b0;
  endfunction

  class stretch_scoreboard;
    logic [uvs_pkg::CFG_W-1:0] extra;
    logic [ACC_W-1:0]          acc;
    logic [7:0]                part [3];
    int unsigned               part_cnt;
    int unsigned               char_len;
    out_beat_t                 expected_q [$];
    int                        fails;

    function new();
      extra    = '0;
      acc      = '0;
      part_cnt = 0;
      char_len = 0;
      fails    = 0;
    endfunction

    function void set_extra(input logic [uvs_pkg::CFG_W-1:0] v);
      extra = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void fail(input string msg);
      fails++;
      if (fails <= 10) $display("[%0t] result error: %s", $time, msg);
    endfunction

    // append one expected result at the tail
    function void queue_beat(input logic [7:0] data, input logic last, input logic dup);
      out_beat_t beat;
      beat.data = data;
      beat.last = last;
      beat.dup  = dup;
      expected_q.insert(expected_q.size(), beat);
    endfunction

    // queue one complete character plus any vowel copies
    function void emit_char(input logic [3:0][7:0] chars, input int unsigned len);
      bit               vowel;
      int unsigned      copies;
      int unsigned      total;
      int unsigned      k;
      logic [ACC_W-1:0] add;
      vowel  = 1'b0;
      copies = 0;
      k      = 0;
      if (len == 1) vowel = stretchable({3'b000, chars[0]});
      else if (len == 2) vowel = stretchable({chars[0][4:0], chars[1][5:0]});
      if (vowel && extra != 0) begin
        add = (extra > EXTRA_MAX) ? ACC_W'(EXTRA_MAX) : ACC_W'(extra);
        acc = acc + add;
        while (acc >= ACC_ONE && copies < 2) begin
          acc = acc - ACC_W'(ACC_ONE);
          copies++;
        end
      end
      total = len * (copies + 1);
      for (int unsigned c = 0; c <= copies; c++) begin
        for (int unsigned j = 0; j < len; j++) begin
          queue_beat(chars[j], k == total - 1, c != 0);
          k++;
        end
      end
    endfunction

    function void take_byte(input logic [7:0] b, input logic [2:0] left, input logic first);
      logic [2:0]       rem;
      int unsigned      len;
      logic [3:0][7:0]  chars;
      chars = '0;
      if (first) begin
        acc      = '0;
        part_cnt = 0;
        char_len = 0;
      end
      rem = (left > 3'd4) ? 3'd4 : left;
      if (char_len == 0) begin
        len = 0;
        if (rem != 0) begin
          if (!b[7]) len = 1;
          else if (b[7:5] == 3'b110 && rem >= 2) len = 2;
          else if (b[7:4] == 4'b1110 && rem >= 3) len = 3;
          else if (b[7:3] == 5'b11110 && rem >= 4) len = 4;
        end
        if (len == 0) begin
          // raw passthrough, accumulator untouched
          queue_beat(b, 1'b1, 1'b0);
        end else if (len == 1) begin
          chars[0] = b;
          emit_char(chars, 1);
        end else begin
          part[0]  = b;
          part_cnt = 1;
          char_len = len;
        end
        return;
      end
      // continuation byte: top bits and bytes_left not looked at
      if (part_cnt + 1 < char_len) begin
        part[part_cnt] = b;
        part_cnt++;
        return;
      end
      for (int unsigned j = 0; j < part_cnt; j++) chars[j] = part[j];
      chars[part_cnt] = b;
      len      = part_cnt + 1;
      part_cnt = 0;
      char_len = 0;
      emit_char(chars, len);
    endfunction

    function void match_output(input logic [7:0] data, input logic last, input logic dup);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        fail($sformatf("unexpected byte %02h last %0b dup %0b", data, last, dup));
        return;
      end
      want = expected_q.pop_front();
      if (want.data !== data || want.last !== last || want.dup !== dup)
        fail($sformatf("expected byte %02h last %0b dup %0b, got byte %02h last %0b dup %0b",
                       want.data, want.last, want.dup, data, last, dup));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [uvs_pkg::CFG_W-1:0] cfg_wdata;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  stretch_scoreboard sb = new();

  int send_idle_pct;
  int stall_pct;
  int phase_items;
  bit pressure_go;
  bit hold_off;

  utf8_vowel_stretcher #(.ACC_FRACTION_BITS(FRAC_BITS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.match_output(out_ch.out_byte, out_ch.run_last, out_ch.is_duplicate);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic [2:0] left, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.in_byte         <= b;
    in_ch.bytes_left      <= left;
    in_ch.first_of_string <= first;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_byte(b, left, first);
    phase_items++;
  endtask

  // wait out all results, then let any trailing partial byte settle
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_extra(input logic [uvs_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_extra(v);
  endtask

  // mostly well-formed strings, with some noise and broken framing
  task automatic send_phrase();
    logic [7:0]  txt [$];
    logic [10:0] cp;
    logic [2:0]  left;
    logic        first;
    int unsigned kind;
    int unsigned full;
    int unsigned n_left;
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        cp = VOWELS[$urandom_range(11)];
        txt.insert(txt.size(), cp[7:0]);
      end else if (kind < 48) begin
        txt.insert(txt.size(), 8'($urandom_range(127)));
      end else if (kind < 68) begin
        cp = VOWELS[$urandom_range(37, 12)];
        txt.insert(txt.size(), {3'b110, cp[10:6]});
        txt.insert(txt.size(), {2'b10, cp[5:0]});
      end else if (kind < 78) begin
        txt.insert(txt.size(), {3'b110, 5'($urandom)});
        txt.insert(txt.size(), {2'b10, 6'($urandom)});
      end else if (kind < 85) begin
        txt.insert(txt.size(), {4'b1110, 4'($urandom)});
        repeat (2) txt.insert(txt.size(), {2'b10, 6'($urandom)});
      end else if (kind < 92) begin
        txt.insert(txt.size(), {5'b11110, 3'($urandom)});
        repeat (3) txt.insert(txt.size(), {2'b10, 6'($urandom)});
      end else begin
        txt.insert(txt.size(), 8'($urandom));
      end
    end
    full = txt.size();
    // truncated string: bytes_left still counts the lost tail
    if (full > 1 && $urandom_range(99) < 6) void'(txt.pop_back());
    foreach (txt[i]) begin
      n_left = full - i;
      left   = (n_left > 4) ? 3'd4 : 3'(n_left);
      if ($urandom_range(99) < 6) left = 3'($urandom_range(7));
      first = (i == 0);
      if ($urandom_range(99) < 5) first = ~first;
      if ($urandom_range(99) < 3) txt[i] = 8'($urandom);
      send_byte(txt[i], left, first);
    end
  endtask

  task automatic run_phase(input logic [uvs_pkg::CFG_W-1:0] extra, input int idle,
                           input int stall, input int n_items, input bit squeeze);
    write_extra(extra);
    send_idle_pct = idle;
    stall_pct     = stall;
    phase_items   = 0;
    if (squeeze) pressure_go = 1'b1;
    while (phase_items < n_items) send_phrase();
    drain_and_settle();
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.in_byte         = '0;
    in_ch.bytes_left      = '0;
    in_ch.first_of_string = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    phase_items           = 0;
    pressure_go           = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: factor 1.5 so copies vary between one and two
    write_extra(10'd384);
    send_byte(8'h61, 3'd4, 1'b1);   // a
    send_byte(8'h65, 3'd3, 1'b0);   // e, accumulator reaches two units
    send_byte(8'h62, 3'd2, 1'b0);
    send_byte(8'h00, 3'd1, 1'b0);
    send_byte(8'hFF, 3'd4, 1'b1);   // invalid lead
    send_byte(8'h80, 3'd4, 1'b0);   // stray continuation as lead
    send_byte(8'hC9, 3'd4, 1'b0);   // schwa, two bytes
    send_byte(8'h99, 3'd3, 1'b0);
    send_byte(8'hC1, 3'd2, 1'b0);   // overlong two-byte 'a' still stretches
    send_byte(8'hA1, 3'd1, 1'b0);
    send_byte(8'hE0, 3'd4, 1'b1);   // continuation bits and bytes_left unchecked
    send_byte(8'h41, 3'd0, 1'b0);
    send_byte(8'h3F, 3'd7, 1'b0);
    send_byte(8'hF0, 3'd4, 1'b0);   // four-byte character
    send_byte(8'h9F, 3'd3, 1'b0);
    send_byte(8'h98, 3'd2, 1'b0);
    send_byte(8'h80, 3'd1, 1'b0);
    send_byte(8'hE2, 3'd2, 1'b1);   // longer than what remains
    send_byte(8'h6F, 3'd0, 1'b0);   // zero remaining: raw, no vowel check
    send_byte(8'h75, 3'd7, 1'b0);   // remaining above four
    send_byte(8'hC3, 3'd4, 1'b0);   // partial char dropped by new string
    send_byte(8'h69, 3'd3, 1'b1);
    send_byte(8'hE0, 3'd3, 1'b0);   // overlong three-byte 'A', not a vowel
    send_byte(8'h81, 3'd2, 1'b0);
    send_byte(8'h81, 3'd1, 1'b0);
    drain_and_settle();

    run_phase(10'd0,    0,  0,  50, 1'b0);
    run_phase(10'd512,  54, 0,  50, 1'b0);
    run_phase(10'd1023, 0,  54, 50, 1'b0);
    run_phase(10'($urandom_range(511, 1)), 28, 28, 50, 1'b0);
    run_phase(10'd100,  0,  0,  50, 1'b1);
    run_phase(10'($urandom_range(1023)),   28, 28, 50, 1'b0);

    if (sb.pending() != 0) sb.fail($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
